/* src/sitgc_pkg.sv */
// ----------------------------------------------------------------------------
// sitgc_pkg
// Shared constants for the spiral index to grid coordinate converter.
// ----------------------------------------------------------------------------
package sitgc_pkg;

	localparam int INDEX_WIDTH_DEF = 32;
	localparam int COORD_W         = 17;

	function automatic int root_bits(input int index_width);
		return (index_width + 1) / 2;
	endfunction

endpackage

/* src/spiral_index_to_grid_coordinates_core.sv */
// Throughput: one request per cycle; one root cell per result bit, each stage
// holds one request and a stalled result only backs up the stages behind it.
// Reset: arst_n clears all valid flags asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
// spiral_index_to_grid_coordinates_core
// Square-shell spiral position to 1-based column/row, via a chain of
// integer square root cells and a two-stage placement step.
// ----------------------------------------------------------------------------
module spiral_index_to_grid_coordinates_core #(
	parameter int INDEX_WIDTH = sitgc_pkg::INDEX_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          position_valid,
	output logic                          position_ready,
	input  logic [INDEX_WIDTH-1:0]        position,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [sitgc_pkg::COORD_W-1:0] column,
	output logic [sitgc_pkg::COORD_W-1:0] row
);

	localparam int RB = sitgc_pkg::root_bits(INDEX_WIDTH);

	logic            valid_c [0:RB];
	logic            ready_c [0:RB];
	logic [RB:0]     rem_c   [0:RB];
	logic [RB-1:0]   root_c  [0:RB];
	logic [2*RB-1:0] bits_c  [0:RB];

	assign valid_c[0]     = position_valid;
	assign position_ready = ready_c[0];
	assign rem_c[0]       = '0;
	assign root_c[0]      = '0;
	assign bits_c[0]      = (2*RB)'(position);

	for (genvar i = 0; i < RB; i++) begin : g_cell
		sitgc_root_cell #(
			.RB(RB)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[i]),
			.up_ready (ready_c[i]),
			.up_rem   (rem_c[i]),
			.up_root  (root_c[i]),
			.up_bits  (bits_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_ready (ready_c[i+1]),
			.dn_rem   (rem_c[i+1]),
			.dn_root  (root_c[i+1]),
			.dn_bits  (bits_c[i+1])
		);
	end

	sitgc_place #(
		.RB(RB)
	) u_place (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (valid_c[RB]),
		.up_ready  (ready_c[RB]),
		.up_rem    (rem_c[RB]),
		.up_root   (root_c[RB]),
		.dn_valid  (result_valid),
		.dn_ready  (result_ready),
		.dn_column (column),
		.dn_row    (row)
	);

endmodule

/* src/sitgc_root_cell.sv */
// ----------------------------------------------------------------------------
// sitgc_root_cell
// One digit step of the integer square root: brings down two index bits,
// tries the next root bit and keeps the partial remainder.
// ----------------------------------------------------------------------------
module sitgc_root_cell #(
	parameter int RB = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  logic [RB:0]     up_rem,
	input  logic [RB-1:0]   up_root,
	input  logic [2*RB-1:0] up_bits,
	output logic            dn_valid,
	input  logic            dn_ready,
	output logic [RB:0]     dn_rem,
	output logic [RB-1:0]   dn_root,
	output logic [2*RB-1:0] dn_bits
);

	logic            valid_q;
	logic [RB:0]     rem_q;
	logic [RB-1:0]   root_q;
	logic [2*RB-1:0] bits_q;

	logic [RB+2:0] cat;
	logic [RB+2:0] trial;
	logic [RB+2:0] diff;
	logic          take;

	assign cat   = {up_rem, up_bits[2*RB-1 -: 2]};
	assign trial = {1'b0, up_root, 2'b01};
	assign diff  = cat - trial;
	assign take  = (cat >= trial);

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			rem_q  <= take ? diff[RB:0] : cat[RB:0];
			root_q <= {up_root[RB-2:0], take};
			bits_q <= up_bits << 2;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rem   = rem_q;
	assign dn_root  = root_q;
	assign dn_bits  = bits_q;

endmodule

/* src/sitgc_place.sv */
// ----------------------------------------------------------------------------
// sitgc_place
// Turns floor root and remainder into shell, back distance and the
// column/row of the cell. Two registered stages.
// ----------------------------------------------------------------------------
module sitgc_place #(
	parameter int RB = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic [RB:0]                   up_rem,
	input  logic [RB-1:0]                 up_root,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output logic [sitgc_pkg::COORD_W-1:0] dn_column,
	output logic [sitgc_pkg::COORD_W-1:0] dn_row
);

	localparam int CW = sitgc_pkg::COORD_W;

	logic          valid_s1;
	logic [RB:0]   up_s1;
	logic [RB:0]   d_s1;
	logic          zero_s1;
	logic          ready_s1;

	logic          valid_s2;
	logic [CW-1:0] col_s2;
	logic [CW-1:0] row_s2;
	logic          ready_s2;

	logic          partial;
	logic [RB:0]   up_c;
	logic [RB:0]   d_c;

	logic          odd;
	logic          near;
	logic [RB+1:0] far_w;
	logic [RB:0]   far;
	logic [RB:0]   step;
	logic [RB:0]   col_u;
	logic [RB:0]   row_u;
	logic [RB+CW:0] col_w;
	logic [RB+CW:0] row_w;

	assign partial = (up_rem != '0);
	assign up_c    = partial ? ({1'b0, up_root} + 1'b1) : {1'b0, up_root};
	assign d_c     = partial ? ({up_root, 1'b1} - up_rem) : '0;

	assign ready_s2 = !valid_s2 || dn_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && up_valid) begin
			up_s1   <= up_c;
			d_s1    <= d_c;
			zero_s1 <= !partial && (up_root == '0);
		end
	end

	// near leg runs away from the end corner, far leg comes back from (up, up)
	assign odd   = up_s1[0];
	assign near  = (d_s1 < up_s1);
	assign far_w = {up_s1, 1'b0} - {{(RB+1){1'b0}}, 1'b1} - {1'b0, d_s1};
	assign far   = far_w[RB:0];
	assign step  = d_s1 + 1'b1;

	always_comb begin
		if (near) begin
			col_u = odd ? step : up_s1;
			row_u = odd ? up_s1 : step;
		end else begin
			col_u = odd ? up_s1 : far;
			row_u = odd ? far : up_s1;
		end
	end

	assign col_w = {{CW{1'b0}}, col_u};
	assign row_w = {{CW{1'b0}}, row_u};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			col_s2 <= zero_s1 ? '0 : col_w[CW-1:0];
			row_s2 <= zero_s1 ? '0 : row_w[CW-1:0];
		end
	end

	assign dn_valid  = valid_s2;
	assign dn_column = col_s2;
	assign dn_row    = row_s2;

endmodule

/* src/sitgc_checker.sv */
// ----------------------------------------------------------------------------
// sitgc_checker
// Port-level checks for the spiral coordinate converter, bound to the core.
// ----------------------------------------------------------------------------
module sitgc_checker #(
	parameter int INDEX_WIDTH = sitgc_pkg::INDEX_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          position_valid,
	input logic                          position_ready,
	input logic [INDEX_WIDTH-1:0]        position,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [sitgc_pkg::COORD_W-1:0] column,
	input logic [sitgc_pkg::COORD_W-1:0] row
);

	// empty output stage means the whole chain can take a request
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> position_ready)
		else $error("request refused while output stage empty");

	// zero position marks both coordinates zero, never just one
	a_zero_mark: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((column == '0) == (row == '0)))
		else $error("column and row disagree on error mark");

	a_first_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !result_valid)
		else $error("result valid right after reset");

	a_request_held: assert property (@(posedge clk) disable iff (!arst_n)
		position_valid && !position_ready |=> position_valid && $stable(position))
		else $error("waiting request changed");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(column) && $stable(row))
		else $error("stalled result changed");

endmodule

bind spiral_index_to_grid_coordinates_core sitgc_checker #(
	.INDEX_WIDTH(INDEX_WIDTH)
) u_sitgc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.position_valid (position_valid),
	.position_ready (position_ready),
	.position       (position),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.column         (column),
	.row            (row)
);
